@@ rtl/ssd_pkg.sv @@
// Package for the multiplexed seven-segment display driver.
// Holds the transaction types, command and symbol codes and the segment table.
// No dependencies.
package ssd_pkg;

  localparam int unsigned BRIGHT_SLOTS_DEF = 10;
  localparam int unsigned DIGITS_DEF       = 4;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [16:0] DIV10_MUL   = 17'h0CCCD;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam logic [15:0] LED_MASK = 16'h3000;

  typedef enum logic [1:0] {
    CMD_SHOW    = 2'd0,
    CMD_LED_ON  = 2'd1,
    CMD_LED_OFF = 2'd2
  } cmd_e;

  localparam logic [3:0] SYM_HYPHEN = 4'd10;
  localparam logic [3:0] SYM_BLANK  = 4'd11;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] number;
    logic        hide;
    logic [2:0]  led_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] serial_word;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic        is_show;
    logic        led_on;
    logic [1:0]  led_bits;
    logic        hide;
    logic [15:0] number;
  } q_entry_t;

  function automatic logic [15:0] seg_of(input logic [3:0] sym);
    logic [15:0] seg;
    case (sym)
      4'd0:       seg = 16'h03F0;
      4'd1:       seg = 16'h0060;
      4'd2:       seg = 16'h05B0;
      4'd3:       seg = 16'h04F0;
      4'd4:       seg = 16'h0660;
      4'd5:       seg = 16'h06D0;
      4'd6:       seg = 16'h07D0;
      4'd7:       seg = 16'h0070;
      4'd8:       seg = 16'h07F0;
      4'd9:       seg = 16'h06F0;
      SYM_HYPHEN: seg = 16'h0400;
      default:    seg = 16'h0000;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/ssd_front.sv @@
// Front end of the display driver: accepts commands and classifies them.
// Produces queue entries for the back end and drops commands that emit nothing.
// Depends on ssd_pkg.
module ssd_front (
  input  logic              in_valid,
  input  ssd_pkg::in_item_t in_item,
  output logic              in_stall,
  input  logic              q_full,
  output logic              q_push,
  output ssd_pkg::q_entry_t q_entry
);
  import ssd_pkg::*;

  logic keep;

  always_comb begin
    keep             = 1'b0;
    q_entry.is_show  = 1'b0;
    q_entry.led_on   = 1'b0;
    q_entry.led_bits = 2'b00;
    q_entry.hide     = in_item.hide;
    q_entry.number   = in_item.number;
    unique case (in_item.command)
      CMD_SHOW: begin
        keep            = 1'b1;
        q_entry.is_show = 1'b1;
      end
      CMD_LED_ON, CMD_LED_OFF: begin
        keep           = ~in_item.led_index[2];
        q_entry.led_on = (in_item.command == CMD_LED_ON);
        case (in_item.led_index[1:0])
          2'd0:    q_entry.led_bits = 2'b01;
          2'd1:    q_entry.led_bits = 2'b10;
          2'd2:    q_entry.led_bits = 2'b11;
          default: q_entry.led_bits = 2'b00;
        endcase
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full & keep;

endmodule

@@ rtl/ssd_fifo.sv @@
// Short queue between the front and back ends of the display driver.
// Register-based, one write and one read port, show-ahead read.
// Depends on ssd_pkg.
module ssd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ssd_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ssd_pkg::q_entry_t head
);
  import ssd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  q_entry_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;

  assign full       = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("Queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("Queue read while empty.");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("Queue fill count out of range.");
`endif

endmodule

@@ rtl/ssd_back.sv @@
// Back end of the display driver: emits serial words from queued commands.
// Holds the brightness register, the last serial word and the output register.
// Depends on ssd_pkg.
module ssd_back #(
  parameter int unsigned BRIGHT_SLOTS = ssd_pkg::BRIGHT_SLOTS_DEF,
  parameter int unsigned DIGITS       = ssd_pkg::DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [3:0]         cfg_data,
  input  logic               head_valid,
  input  ssd_pkg::q_entry_t  head,
  output logic               pop,
  output logic               out_valid,
  output ssd_pkg::out_item_t out_item,
  input  logic               out_stall
);
  import ssd_pkg::*;

  localparam int unsigned SLOT_W = $clog2(BRIGHT_SLOTS);
  localparam int unsigned DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BRIGHT_SLOTS - 1);
  localparam logic [DIG_W-1:0]  DIG_LAST  = DIG_W'(DIGITS - 1);

  logic [3:0]        bright_r, bright_red;
  logic [15:0]       shift_word_r, shift_word_nxt;
  logic              busy_r, busy_nxt;
  logic [15:0]       n_r, n_nxt;
  logic              hide_r, hide_nxt;
  logic [DIG_W-1:0]  dig_r, dig_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              load;
  logic [15:0]       cur_n;
  logic              cur_hide;
  logic [DIG_W-1:0]  cur_dig;
  logic [SLOT_W-1:0] cur_slot;
  logic [33:0]       prod;
  logic [15:0]       quot;
  logic [15:0]       rem;
  logic [3:0]        sym;
  logic [1:0]        pos;
  logic              lit;
  logic              show_last;
  logic [15:0]       show_word;
  logic [15:0]       led_word;

  always_comb begin
    bright_red = '0;
    for (int v = 0; v < 16; v++) begin
      if (cfg_data == 4'(v)) begin
        bright_red = 4'(v % BRIGHT_SLOTS);
      end
    end
  end

  assign load     = ~out_valid_r | ~out_stall;
  assign cur_n    = busy_r ? n_r : head.number;
  assign cur_hide = busy_r ? hide_r : head.hide;
  assign cur_dig  = busy_r ? dig_r : '0;
  assign cur_slot = busy_r ? slot_r : '0;

  assign prod = {18'd0, cur_n} * {17'd0, DIV10_MUL};
  assign quot = {3'b000, prod[DIV10_SHIFT +: 13]};
  assign rem  = cur_n - {quot[12:0], 3'b000} - {quot[14:0], 1'b0};

  always_comb begin
    if (cur_dig == '0) begin
      sym = rem[3:0];
    end else if (cur_n == '0) begin
      sym = SYM_BLANK;
    end else if (cur_hide) begin
      sym = SYM_HYPHEN;
    end else begin
      sym = rem[3:0];
    end
  end

  assign pos       = 2'(DIGITS - 1) - 2'(cur_dig);
  assign lit       = (4'(cur_slot) <= bright_r);
  assign show_last = (cur_dig == DIG_LAST) & (cur_slot == SLOT_LAST);
  assign show_word = lit ? ((shift_word_r & LED_MASK) | {pos, 14'd0} | seg_of(sym))
                         : (shift_word_r & LED_MASK);
  assign led_word  = head.led_on ? (shift_word_r | {2'b00, head.led_bits, 12'd0})
                                 : (shift_word_r & ~{2'b00, head.led_bits, 12'd0});

  always_comb begin
    busy_nxt       = busy_r;
    n_nxt          = n_r;
    hide_nxt       = hide_r;
    dig_nxt        = dig_r;
    slot_nxt       = slot_r;
    shift_word_nxt = shift_word_r;
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    pop            = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b0;
      if (busy_r || (head_valid && head.is_show)) begin
        pop            = ~busy_r;
        shift_word_nxt = show_word;
        out_valid_nxt  = 1'b1;
        out_item_nxt   = '{serial_word: show_word, last_of_run: show_last};
        hide_nxt       = cur_hide;
        if (cur_slot == SLOT_LAST) begin
          slot_nxt = '0;
          dig_nxt  = cur_dig + 1'b1;
          n_nxt    = quot;
          busy_nxt = ~show_last;
        end else begin
          slot_nxt = cur_slot + 1'b1;
          dig_nxt  = cur_dig;
          n_nxt    = cur_n;
          busy_nxt = 1'b1;
        end
      end else if (head_valid) begin
        pop            = 1'b1;
        shift_word_nxt = led_word;
        out_valid_nxt  = 1'b1;
        out_item_nxt   = '{serial_word: led_word, last_of_run: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r     <= '0;
      shift_word_r <= '0;
      busy_r       <= 1'b0;
      dig_r        <= '0;
      slot_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bright_r <= bright_red;
      end
      shift_word_r <= shift_word_nxt;
      busy_r       <= busy_nxt;
      dig_r        <= dig_nxt;
      slot_r       <= slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    hide_r     <= hide_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !busy_r)
    else $error("Queue popped during a show run.");
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (load && busy_r && !show_last) |=> busy_r)
    else $error("Show run ended before its final word.");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (32'(slot_r) < BRIGHT_SLOTS) && (32'(dig_r) < DIGITS))
    else $error("Slot or digit counter out of range.");
  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bright_r) < BRIGHT_SLOTS)
    else $error("Brightness register out of range.");
`endif

endmodule

@@ rtl/seven_segment_mux_pwm_driver.sv @@
// Top level of the multiplexed seven-segment display driver.
// Instantiates ssd_front, ssd_fifo and ssd_back; depends on ssd_pkg.
//
// A show command produces DIGITS*BRIGHT_SLOTS serial words (40 by default), one
// per cycle, units digit first at the highest position; each digit spans
// BRIGHT_SLOTS words, lit in the slots up to the brightness value and dark in
// the rest. An LED command with a valid index produces one word; ignored
// commands produce none. The back-end word emitter sets the rate: one word per
// cycle when the output is not stalled. A two-entry queue decouples input
// acceptance, so commands are taken every cycle while it has room. The user must
// write brightness through the cfg port while the block is idle (not enforced).
module seven_segment_mux_pwm_driver #(
  parameter int unsigned BRIGHT_SLOTS = ssd_pkg::BRIGHT_SLOTS_DEF,
  parameter int unsigned DIGITS       = ssd_pkg::DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  input  ssd_pkg::in_item_t  in_item,
  output logic               in_stall,
  output logic               out_valid,
  output ssd_pkg::out_item_t out_item,
  input  logic               out_stall
);
  import ssd_pkg::*;

  logic     q_full;
  logic     q_push;
  q_entry_t q_entry;
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_head;

  assign cfg_ready = 1'b1;

  ssd_front u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  ssd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  ssd_back #(
    .BRIGHT_SLOTS (BRIGHT_SLOTS),
    .DIGITS       (DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .out_stall  (out_stall)
  );

endmodule
